// ===== src/positional_insert_delete_list_assert.svh =====
// assertion macros for the positional insert/delete list
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

// same-cycle implication
`define PIDL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pidl assertion failed");

// next-cycle implication
`define PIDL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pidl assertion failed");

`endif

// ===== src/pidl_pkg.sv =====
// types and constants shared by the positional insert/delete list
`default_nettype none

package pidl_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [2:0] {
      CMD_APPEND  = 3'd0,
      CMD_INSERT  = 3'd1,
      CMD_DELETE  = 3'd2,
      CMD_REPLACE = 3'd3,
      CMD_PUSH    = 3'd4,
      CMD_POP     = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_UP   = 2'd1,
      CELL_SHIFT_DOWN = 2'd2,
      CELL_WRITE      = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic               popped_valid;
      logic [4:0]         entry_count;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== src/pidl_cell.sv =====
// one list entry: holds, takes a neighbor's value, or takes the new value
`default_nettype none

module pidl_cell
   import pidl_pkg::*;
#(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic [IDX_W-1:0]   pos,
   input  wire logic signed [31:0] left_value,
   input  wire logic signed [31:0] right_value,
   output logic signed [31:0]      value
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_SHIFT_UP: begin
            if (MY_IDX == pos) begin
               value_in = ctl.value;
            end else if (MY_IDX > pos) begin
               value_in = left_value;
            end
         end
         CELL_SHIFT_DOWN: begin
            if (MY_IDX >= pos) begin
               value_in = right_value;
            end
         end
         CELL_WRITE: begin
            if (MY_IDX == pos) begin
               value_in = ctl.value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== src/positional_insert_delete_list.sv =====
// a command's result beat appears in the cycle after the command is accepted
// throughput: one command per cycle unless rsp_stall holds a waiting beat; every cell shifts in the same cycle
// a result beat waiting on rsp_stall holds off new commands until it is taken
// reset clears the entry count and the result valid; entry contents are not cleared
`default_nettype none

module positional_insert_delete_list
   import pidl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // index into the row of cells, count that reaches capacity, and a compare width
   // wide enough for both the count and the 5-bit position field
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   cell_ctl_type       ctl;
   logic [IDX_W-1:0]   cell_pos;
   logic signed [31:0] cell_value [CAPACITY];

   logic             req_fire;
   logic             full;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] cnt_out;

   // a new command may enter whenever the output register is free or being drained
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign pos_ext = CMP_W'(req_data.position);
   assign cnt_ext = CMP_W'(count_ff);

   // decode the command into one broadcast control for the whole row
   always_comb begin
      ctl.op    = CELL_HOLD;
      ctl.value = req_data.value;
      count_in  = count_ff;
      rsp_data_in              = rsp_data_ff;
      rsp_data_in.popped_value = '0;
      rsp_data_in.popped_valid = 1'b0;
      rsp_data_in.status       = ST_DONE;

      if (IDX_W <= 5) begin
         cell_pos = IDX_W'(req_data.position);
      end else begin
         cell_pos = IDX_W'(pos_ext);
      end

      if (req_fire) begin
         case (req_data.command)
            CMD_APPEND: begin
               if (full) begin
                  rsp_data_in.status = ST_FULL;
               end else begin
                  // append is an insert at the current end
                  ctl.op   = CELL_SHIFT_UP;
                  cell_pos = IDX_W'(count_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_INSERT: begin
               if (full) begin
                  rsp_data_in.status = ST_FULL;
               end else if (pos_ext > cnt_ext) begin
                  rsp_data_in.status = ST_RANGE;
               end else begin
                  ctl.op   = CELL_SHIFT_UP;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_DELETE: begin
               if (pos_ext >= cnt_ext) begin
                  rsp_data_in.status = ST_RANGE;
               end else begin
                  ctl.op   = CELL_SHIFT_DOWN;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_REPLACE: begin
               if (pos_ext >= cnt_ext) begin
                  rsp_data_in.status = ST_RANGE;
               end else begin
                  ctl.op = CELL_WRITE;
               end
            end
            CMD_PUSH: begin
               if (full) begin
                  rsp_data_in.status = ST_FULL;
               end else begin
                  ctl.op   = CELL_SHIFT_UP;
                  cell_pos = '0;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = ST_EMPTY;
               end else begin
                  // front entry leaves through cell zero as the row shifts down
                  ctl.op   = CELL_SHIFT_DOWN;
                  cell_pos = '0;
                  count_in = count_ff - CNT_W'(1);
                  rsp_data_in.popped_value = cell_value[0];
                  rsp_data_in.popped_valid = 1'b1;
               end
            end
            default: ctl.op = CELL_HOLD;
         endcase
      end

      // entry count field is the low five bits of the new count
      cnt_out                 = CMP_W'(count_in);
      rsp_data_in.entry_count = cnt_out[4:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   // row of cells, each wired to its two neighbors; the ends feed back on themselves
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = cell_value[i];
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      pidl_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (cell_pos),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload loads only on an accepted command, so a stalled beat holds
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "positional_insert_delete_list_assert.svh"

   // count never passes the capacity
   `PIDL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   // every accepted command leaves a result beat behind it
   `PIDL_ASSERT_NEXT(a_fire_gives_beat, clock, reset, req_fire, rsp_valid_ff)
   // the reported count matches the stored count right after the command
   `PIDL_ASSERT_NEXT(a_count_report, clock, reset, req_fire,
      rsp_data_ff.entry_count == cnt_ext[4:0])
   // a popped value only comes with a successful status
   `PIDL_ASSERT_NOW(a_pop_status, clock, reset, rsp_valid_ff && rsp_data_ff.popped_valid,
      rsp_data_ff.status == ST_DONE)

endmodule

`default_nettype wire
